@@ hw/rtl/lrss_pkg.sv @@
`default_nettype none

package lrss_pkg;

  // Default table depth and number of LEDs that a mask may address.
  localparam int MAX_STEPS_DEF = 64;
  localparam int NUM_LEDS      = 8;

  // Stream word widths, padded to whole bytes.
  localparam int IN_W   = 104;
  localparam int OUT_W  = 40;
  localparam int KIND_W = 2;

  // Configuration port.
  localparam int ADDR_W_CFG = 3;
  localparam int DATA_W_CFG = 32;
  localparam logic REG_TICK_PERIOD   = 1'b0;
  localparam logic REG_REFIRE_OFFSET = 1'b1;

  localparam logic [7:0]  TICK_PERIOD_RST   = 8'd50;
  localparam logic [15:0] REFIRE_OFFSET_RST = 16'd550;

  // Largest colour value after a ramp.
  localparam logic signed [9:0] COLOUR_MAX = 10'sd255;

  // Accumulator width.
  localparam int ACCUM_W = 17;

  // Mask bits that correspond to real LEDs.
  localparam logic [7:0] LED_MASK = (NUM_LEDS >= 8) ? 8'hFF : 8'((1 << NUM_LEDS) - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  // Input word; the last field listed here sits in the lowest bits.
  typedef struct packed {
    logic [5:0]        pad;
    logic [15:0]       repeat_count;
    logic signed [8:0] blue_ramp;
    logic signed [8:0] green_ramp;
    logic signed [8:0] red_ramp;
    logic [7:0]        blue_start;
    logic [7:0]        green_start;
    logic [7:0]        red_start;
    logic [7:0]        led_mask;
    logic [15:0]       hold_delay;
    logic [5:0]        entry_index;
    logic              led_busy;
  } in_word_t;

  // Result word; the last field listed here sits in the lowest bits.
  typedef struct packed {
    logic [3:0] pad;
    logic       sequence_done;
    logic       running;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] mask_out;
    logic       fired;
    logic       accepted;
  } out_word_t;

  // One step of the table, also the layout of the working copy.
  typedef struct packed {
    logic [15:0]       count;
    logic signed [8:0] blue_ramp;
    logic signed [8:0] green_ramp;
    logic signed [8:0] red_ramp;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [7:0]        mask;
    logic [15:0]       delay;
  } entry_t;

  // Bit reversal of one colour byte.
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Add a signed ramp to a colour and saturate to 0..255.
  function automatic logic [7:0] ramp_sat(input logic [7:0] v, input logic signed [8:0] r);
    logic signed [9:0] s;
    s = signed'({2'b00, v}) + signed'({r[8], r});
    if (s > COLOUR_MAX) begin
      return 8'hFF;
    end else if (s[9]) begin
      return 8'h00;
    end else begin
      return s[7:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/led_ramp_step_sequencer.sv @@
// Each taken word passes the registered table read and execute stage into the result queue.
// Throughput: one word per cycle while the result queue has room; each tick or start word
// does one read of the step table and one read-modify-write of the working step registers,
// with the next step address forwarded. A three-word result queue absorbs output stalls.
// Reset: synchronous; clears the queue and the sequence state but the working copy; restores the registers.
// The step table is not cleared and holds no defined value until an entry is loaded.
`default_nettype none

module led_ramp_step_sequencer #(
  parameter int MAX_STEPS = lrss_pkg::MAX_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // s_tdata: led_busy, entry_index, hold_delay, led_mask, red_start, green_start,
  // blue_start, red_ramp, green_ramp, blue_ramp, repeat_count, zero pad
  input  wire logic [lrss_pkg::IN_W-1:0]      s_tdata,
  // s_tuser: kind
  input  wire logic [lrss_pkg::KIND_W-1:0]    s_tuser,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // m_tdata: accepted, fired, mask_out, red_out, green_out, blue_out, running,
  // sequence_done, zero pad
  output logic [lrss_pkg::OUT_W-1:0]          m_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lrss_pkg::ADDR_W_CFG-1:0] paddr,
  input  wire logic [lrss_pkg::DATA_W_CFG-1:0] pwdata,
  output logic [lrss_pkg::DATA_W_CFG-1:0]     prdata,
  output logic                                pready
);

  import lrss_pkg::*;

  localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int SUM_W  = 17;
  localparam int Q_DEPTH = 3;

  // Configuration registers.
  logic [7:0]  tick_period;
  logic [15:0] refire_offset;

  // Step table and its registered read data.
  entry_t table_mem [MAX_STEPS];
  entry_t rd_entry;

  // Sequence state.
  logic               active, active_next;
  logic [CNT_W-1:0]   cur_step, cur_step_next;
  logic [CNT_W-1:0]   last_step, last_step_next;
  logic [ACCUM_W-1:0] wait_accum, wait_accum_next;
  entry_t             work, work_next;

  // Execute stage.
  logic             s2_valid;
  kind_t            s2_kind;
  logic             s2_busy;
  logic             s2_load_ok;
  logic             s2_start_ok;
  logic [CNT_W-1:0] s2_idx;
  logic [15:0]      s2_count;

  // Result queue.
  out_word_t  q_mem [Q_DEPTH];
  logic [1:0] q_wr, q_rd, q_cnt;
  out_word_t  res;

  // Input side decode.
  in_word_t          in_word;
  kind_t             in_kind;
  logic              in_fire;
  logic              in_idx_ok;
  logic [2:0]        inflight;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            new_entry;

  // Execute helpers.
  logic [SUM_W-1:0] end_sum;
  logic [15:0]      count_dec;
  logic [CNT_W-1:0] nx_step;
  logic             q_push, q_pop;
  logic             cfg_we;

  assign in_word   = in_word_t'(s_tdata);
  assign in_kind   = kind_t'(s_tuser);
  assign inflight  = {1'b0, q_cnt} + {2'b00, s2_valid};
  assign s_tready  = (inflight <= 3'd2);
  assign in_fire   = s_tvalid & s_tready;
  assign in_idx_ok = (32'(in_word.entry_index) < MAX_STEPS);

  // Table entry built from a load word.
  always_comb begin
    new_entry.delay      = in_word.hold_delay;
    new_entry.mask       = in_word.led_mask;
    new_entry.red        = in_word.red_start;
    new_entry.green      = in_word.green_start;
    new_entry.blue       = in_word.blue_start;
    new_entry.red_ramp   = in_word.red_ramp;
    new_entry.green_ramp = in_word.green_ramp;
    new_entry.blue_ramp  = in_word.blue_ramp;
    new_entry.count      = in_word.repeat_count;
  end

  // A start reads its first step; a tick reads the step after the one current
  // once the word ahead of it has finished.
  assign wr_addr = ADDR_W'(in_word.entry_index);
  assign rd_addr = (in_kind == KIND_START) ? ADDR_W'(in_word.entry_index)
                                           : ADDR_W'(cur_step_next + 1'b1);

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind == KIND_LOAD) && in_idx_ok) begin
      table_mem[wr_addr] <= new_entry;
    end
    if (in_fire && (in_kind != KIND_LOAD)) begin
      rd_entry <= table_mem[rd_addr];
    end
  end

  // Execute stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_fire;
    end
    if (in_fire) begin
      s2_kind     <= in_kind;
      s2_busy     <= in_word.led_busy;
      s2_load_ok  <= in_idx_ok;
      s2_start_ok <= in_idx_ok;
      s2_idx      <= CNT_W'(in_word.entry_index);
      s2_count    <= in_word.repeat_count;
    end
  end

  assign end_sum   = SUM_W'(s2_idx) + SUM_W'(s2_count);
  assign count_dec = work.count - 16'd1;
  assign nx_step   = cur_step + 1'b1;

  // Next sequence state and the result of the word in the execute stage.
  always_comb begin
    active_next     = active;
    cur_step_next   = cur_step;
    last_step_next  = last_step;
    wait_accum_next = wait_accum;
    work_next       = work;
    res             = '0;
    if (s2_valid) begin
      case (s2_kind)
        KIND_LOAD: begin
          res.accepted = s2_load_ok;
        end
        KIND_START: begin
          if (!active && s2_start_ok) begin
            cur_step_next   = s2_idx;
            last_step_next  = (end_sum > SUM_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                             : CNT_W'(end_sum);
            work_next       = rd_entry;
            wait_accum_next = '0;
            active_next     = 1'b1;
            res.accepted    = 1'b1;
          end
        end
        KIND_TICK: begin
          if (active && !s2_busy) begin
            res.accepted = 1'b1;
            if (wait_accum < {1'b0, work.delay}) begin
              wait_accum_next = wait_accum + {9'd0, tick_period};
            end else begin
              wait_accum_next  = {1'b0, refire_offset};
              res.fired        = 1'b1;
              res.mask_out     = work.mask & LED_MASK;
              res.red_out      = rev8(work.red);
              res.green_out    = rev8(work.green);
              res.blue_out     = rev8(work.blue);
              work_next.red    = ramp_sat(work.red, work.red_ramp);
              work_next.green  = ramp_sat(work.green, work.green_ramp);
              work_next.blue   = ramp_sat(work.blue, work.blue_ramp);
              work_next.count  = count_dec;
              if (count_dec == 16'd0) begin
                if ((nx_step < last_step) && (32'(nx_step) < MAX_STEPS)) begin
                  cur_step_next   = nx_step;
                  work_next       = rd_entry;
                  wait_accum_next = '0;
                end else begin
                  active_next       = 1'b0;
                  res.sequence_done = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.running = active_next;
  end

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      cur_step   <= '0;
      last_step  <= '0;
      wait_accum <= '0;
    end else begin
      active     <= active_next;
      cur_step   <= cur_step_next;
      last_step  <= last_step_next;
      wait_accum <= wait_accum_next;
    end
    work <= work_next;
  end

  // Result queue.
  assign q_push   = s2_valid;
  assign q_pop    = m_tvalid & m_tready;
  assign m_tvalid = (q_cnt != 2'd0);
  assign m_tdata  = q_mem[q_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (q_push) begin
        q_wr <= (q_wr == 2'(Q_DEPTH - 1)) ? 2'd0 : q_wr + 2'd1;
      end
      if (q_pop) begin
        q_rd <= (q_rd == 2'(Q_DEPTH - 1)) ? 2'd0 : q_rd + 2'd1;
      end
      q_cnt <= q_cnt + {1'b0, q_push} - {1'b0, q_pop};
    end
    if (q_push) begin
      q_mem[q_wr] <= res;
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period   <= TICK_PERIOD_RST;
      refire_offset <= REFIRE_OFFSET_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_TICK_PERIOD) begin
        tick_period <= pwdata[7:0];
      end else begin
        refire_offset <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_REFIRE_OFFSET) ? {16'd0, refire_offset}
                                                  : {24'd0, tick_period};

`ifndef NO_ASSERTIONS
  // The queue always has room for the word leaving the execute stage.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (q_cnt < 2'(Q_DEPTH)))
    else $error("result queue overflow");

  // A sequence ends only on a tick.
  a_end_on_tick: assert property (@(posedge clk) disable iff (rst)
    ($fell(active) && !$past(rst)) |-> $past(s2_valid && (s2_kind == KIND_TICK)))
    else $error("sequence ended without a tick");

  // The current step stays inside the table while running.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (32'(cur_step) < MAX_STEPS))
    else $error("current step outside table");
`endif

endmodule

`default_nettype wire
